FILE: hw/rtl/bsa_pkg.sv
// ----------------------------------------------------------------------------
// bsa_pkg
// Shared types, codes and sizes of the deadlock-avoidance allocator.
// ----------------------------------------------------------------------------
package bsa_pkg;

   localparam int NUM_THREADS   = 8;
   localparam int NUM_RES       = 4;
   localparam int CNT_W         = 8;
   localparam int THREAD_W      = $clog2(NUM_THREADS);
   localparam int TCOUNT_W      = $clog2(NUM_THREADS + 1);
   localparam int WORK_W        = CNT_W + TCOUNT_W;
   localparam int CMD_W         = 2;
   localparam int STATUS_W      = 4;
   localparam int ORDER_SLOT_W  = 3;
   localparam int ORDER_W       = 24;
   localparam int ORDER_ENTRIES = ORDER_W / ORDER_SLOT_W;
   localparam int ORDER_IDX_W   = $clog2(ORDER_ENTRIES);
   localparam int SCOUNT_W      = 4;
   localparam int CSR_ADDR_W    = 2;
   localparam int AMT_W         = 8;
   localparam int REQ_USED_W    = THREAD_W + NUM_RES * AMT_W;
   localparam int REQ_DATA_W    = ((REQ_USED_W + 7) / 8) * 8;
   localparam int RSP_USED_W    = THREAD_W + ORDER_W + SCOUNT_W + NUM_RES * AMT_W;
   localparam int RSP_DATA_W    = ((RSP_USED_W + 7) / 8) * 8;

   localparam logic [CNT_W-1:0] CNT_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_REGISTER = 2'd0,
      CMD_REQUEST  = 2'd1,
      CMD_RELEASE  = 2'd2,
      CMD_UNUSED   = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      RS_REGISTERED   = 4'd0,
      RS_FULL         = 4'd1,
      RS_GRANTED      = 4'd2,
      RS_OVER_NEED    = 4'd3,
      RS_OVER_AVAIL   = 4'd4,
      RS_UNSAFE       = 4'd5,
      RS_RELEASED     = 4'd6,
      RS_NOTHING_HELD = 4'd7,
      RS_BAD_THREAD   = 4'd8
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DECODE,
      S_FETCH,
      S_SCAN_RD,
      S_SCAN_EV,
      S_DONE
   } state_type;

   typedef logic [NUM_RES-1:0][CNT_W-1:0]  cnt_vec_type;
   typedef logic [NUM_RES-1:0][WORK_W-1:0] work_vec_type;
   typedef logic [ORDER_ENTRIES-1:0][ORDER_SLOT_W-1:0] order_type;

   typedef struct packed {
      logic [NUM_RES-1:0] fits;
      logic [NUM_RES-1:0] over_need;
      logic [NUM_RES-1:0] over_avail;
      logic               any_held;
   } vu_flags_type;

endpackage

FILE: hw/rtl/bsa_ram.sv
// ----------------------------------------------------------------------------
// bsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/bsa_vec_unit.sv
// ----------------------------------------------------------------------------
// bsa_vec_unit
// Shared lane unit: need, fit and refusal compares, the vector sums and a difference.
// ----------------------------------------------------------------------------
module bsa_vec_unit (
   input  bsa_pkg::cnt_vec_type  max_vec,
   input  bsa_pkg::cnt_vec_type  alloc_vec,
   input  bsa_pkg::work_vec_type work_vec,
   input  bsa_pkg::cnt_vec_type  amt_vec,
   output bsa_pkg::vu_flags_type flags,
   output bsa_pkg::work_vec_type work_sum,
   output bsa_pkg::cnt_vec_type  alloc_sum,
   output bsa_pkg::cnt_vec_type  work_diff
);

   bsa_pkg::cnt_vec_type need;

   always_comb begin
      flags.any_held = 1'b0;
      for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
         need[r]             = max_vec[r] - alloc_vec[r];
         flags.fits[r]       = bsa_pkg::WORK_W'(need[r]) <= work_vec[r];
         flags.over_need[r]  = amt_vec[r] > need[r];
         flags.over_avail[r] = bsa_pkg::WORK_W'(amt_vec[r]) > work_vec[r];
         flags.any_held      = flags.any_held | (alloc_vec[r] != '0);
         work_sum[r]         = work_vec[r] + bsa_pkg::WORK_W'(alloc_vec[r]);
         alloc_sum[r]        = alloc_vec[r] + amt_vec[r];
         work_diff[r]        = work_vec[r][bsa_pkg::CNT_W-1:0] - amt_vec[r];
      end
   end

endmodule

FILE: hw/rtl/bankers_safety_allocator_core.sv
// ----------------------------------------------------------------------------
// bankers_safety_allocator_core
// Banker's algorithm allocator: register claims, grant safe requests, release.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command item (cmd in req_tuser; thread and four amounts
//   in req_tdata). rsp_* returns one result item for every command but the
//   unused code, which gives none. csr_* sets a resource's available count to
//   the written value. Write only while the block idles.
//   Register and bad thread items pass from decode to done, release and
//   refusal items from decode through fetch to done. A granted or unsafe
//   request adds the safety scan: each pass walks thread slots from zero,
//   reading and evaluating each unfinished thread and skipping each finished
//   one, one pass per finisher plus, for an unsafe request, a failing pass
//   that ends by restoring the allocation and available counts.
//   The scan reads one claim row per step from the claim and allocation RAMs
//   through the shared lane unit.
//   One item is worked at a time; req_tready is high only between items, so
//   a new item is not accepted before the block returns to idle.
//   A finished result waits in the output register while the next item is
//   accepted; if rsp_tready stays low, the following result holds in the
//   block until the register frees.
//   Reset clears thread count, available counts and the output valid.
// ----------------------------------------------------------------------------
module bankers_safety_allocator_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // thread[2:0], amount_0[10:3], amount_1[18:11], amount_2[26:19],
   // amount_3[34:27], zero fill
   input  logic [bsa_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  logic [bsa_pkg::CMD_W-1:0]       req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // assigned_thread[2:0], safe_order[26:3], safe_count[30:27],
   // released_0[38:31], released_1[46:39], released_2[54:47],
   // released_3[62:55], zero fill
   output logic [bsa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[3:0]
   output logic [bsa_pkg::STATUS_W-1:0]    rsp_tuser,
   input  logic                            csr_we,
   input  logic [bsa_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  logic [bsa_pkg::CNT_W-1:0]       csr_wdata
);

   bsa_pkg::state_type    state_ff, state_in;
   bsa_pkg::cmd_type      cmd_ff, cmd_in;
   logic [bsa_pkg::THREAD_W-1:0] thread_ff, thread_in;
   bsa_pkg::cnt_vec_type  amt_ff, amt_in;
   logic [bsa_pkg::TCOUNT_W-1:0] tc_ff, tc_in;
   bsa_pkg::cnt_vec_type  avail_ff, avail_in;
   bsa_pkg::cnt_vec_type  old_avail_ff, old_avail_in;
   bsa_pkg::cnt_vec_type  old_alloc_ff, old_alloc_in;
   bsa_pkg::work_vec_type work_ff, work_in;
   logic [bsa_pkg::NUM_THREADS-1:0] done_ff, done_in;
   logic [bsa_pkg::TCOUNT_W-1:0] n_ff, n_in;
   logic [bsa_pkg::TCOUNT_W-1:0] scan_t_ff, scan_t_in;
   bsa_pkg::order_type    order_ff, order_in;

   bsa_pkg::status_type   res_status_ff, res_status_in;
   logic [bsa_pkg::THREAD_W-1:0] res_assigned_ff, res_assigned_in;
   bsa_pkg::order_type    res_order_ff, res_order_in;
   logic [bsa_pkg::SCOUNT_W-1:0] res_count_ff, res_count_in;
   bsa_pkg::cnt_vec_type  res_released_ff, res_released_in;

   logic                  rsp_tvalid_ff, rsp_tvalid_in;
   bsa_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [bsa_pkg::THREAD_W-1:0] rsp_assigned_ff, rsp_assigned_in;
   bsa_pkg::order_type    rsp_order_ff, rsp_order_in;
   logic [bsa_pkg::SCOUNT_W-1:0] rsp_count_ff, rsp_count_in;
   bsa_pkg::cnt_vec_type  rsp_released_ff, rsp_released_in;

   logic                  max_we, alloc_we;
   logic [bsa_pkg::THREAD_W-1:0] max_waddr, alloc_waddr, rd_addr;
   bsa_pkg::cnt_vec_type  max_wdata, alloc_wdata, max_rd, alloc_rd;
   logic [$bits(bsa_pkg::cnt_vec_type)-1:0] max_rd_raw, alloc_rd_raw;

   bsa_pkg::work_vec_type vu_work;
   bsa_pkg::vu_flags_type vu_flags;
   bsa_pkg::work_vec_type vu_work_sum;
   bsa_pkg::cnt_vec_type  vu_alloc_sum, vu_work_diff;

   logic                  refuse;
   bsa_pkg::status_type   refuse_status;
   bsa_pkg::order_type    order_nxt;

   bsa_ram #(
      .WIDTH ($bits(bsa_pkg::cnt_vec_type)),
      .DEPTH (bsa_pkg::NUM_THREADS)
   ) u_max_ram (
      .clock   (clock),
      .wr_en   (max_we),
      .wr_addr (max_waddr),
      .wr_data (max_wdata),
      .rd_addr (rd_addr),
      .rd_data (max_rd_raw)
   );

   bsa_ram #(
      .WIDTH ($bits(bsa_pkg::cnt_vec_type)),
      .DEPTH (bsa_pkg::NUM_THREADS)
   ) u_alloc_ram (
      .clock   (clock),
      .wr_en   (alloc_we),
      .wr_addr (alloc_waddr),
      .wr_data (alloc_wdata),
      .rd_addr (rd_addr),
      .rd_data (alloc_rd_raw)
   );

   assign max_rd   = bsa_pkg::cnt_vec_type'(max_rd_raw);
   assign alloc_rd = bsa_pkg::cnt_vec_type'(alloc_rd_raw);

   bsa_vec_unit u_vec_unit (
      .max_vec   (max_rd),
      .alloc_vec (alloc_rd),
      .work_vec  (vu_work),
      .amt_vec   (amt_ff),
      .flags     (vu_flags),
      .work_sum  (vu_work_sum),
      .alloc_sum (vu_alloc_sum),
      .work_diff (vu_work_diff)
   );

   always_comb begin
      refuse        = 1'b0;
      refuse_status = bsa_pkg::RS_OVER_NEED;
      for (int r = bsa_pkg::NUM_RES - 1; r >= 0; r--) begin
         if (vu_flags.over_need[r]) begin
            refuse        = 1'b1;
            refuse_status = bsa_pkg::RS_OVER_NEED;
         end else if (vu_flags.over_avail[r]) begin
            refuse        = 1'b1;
            refuse_status = bsa_pkg::RS_OVER_AVAIL;
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      thread_in       = thread_ff;
      amt_in          = amt_ff;
      tc_in           = tc_ff;
      avail_in        = avail_ff;
      old_avail_in    = old_avail_ff;
      old_alloc_in    = old_alloc_ff;
      work_in         = work_ff;
      done_in         = done_ff;
      n_in            = n_ff;
      scan_t_in       = scan_t_ff;
      order_in        = order_ff;
      res_status_in   = res_status_ff;
      res_assigned_in = res_assigned_ff;
      res_order_in    = res_order_ff;
      res_count_in    = res_count_ff;
      res_released_in = res_released_ff;
      rsp_tvalid_in   = rsp_tvalid_ff;
      rsp_status_in   = rsp_status_ff;
      rsp_assigned_in = rsp_assigned_ff;
      rsp_order_in    = rsp_order_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_released_in = rsp_released_ff;
      max_we          = 1'b0;
      alloc_we        = 1'b0;
      max_waddr       = thread_ff;
      alloc_waddr     = thread_ff;
      max_wdata       = amt_ff;
      alloc_wdata     = '0;
      rd_addr         = thread_ff;
      order_nxt       = order_ff;
      for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
         vu_work[r] = bsa_pkg::WORK_W'(avail_ff[r]);
      end

      if (rsp_tvalid_ff && rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end

      case (state_ff)
         bsa_pkg::S_IDLE: begin
            if (req_tvalid) begin
               cmd_in    = bsa_pkg::cmd_type'(req_tuser);
               thread_in = req_tdata[bsa_pkg::THREAD_W-1:0];
               for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
                  amt_in[r] = req_tdata[bsa_pkg::THREAD_W + r * bsa_pkg::AMT_W +:
                                        bsa_pkg::CNT_W];
               end
               state_in = bsa_pkg::S_DECODE;
            end
         end
         bsa_pkg::S_DECODE: begin
            res_assigned_in = '0;
            res_order_in    = '0;
            res_count_in    = '0;
            res_released_in = '0;
            case (cmd_ff)
               bsa_pkg::CMD_REGISTER: begin
                  state_in = bsa_pkg::S_DONE;
                  if (tc_ff == bsa_pkg::TCOUNT_W'(bsa_pkg::NUM_THREADS)) begin
                     res_status_in = bsa_pkg::RS_FULL;
                  end else begin
                     max_we          = 1'b1;
                     alloc_we        = 1'b1;
                     max_waddr       = tc_ff[bsa_pkg::THREAD_W-1:0];
                     alloc_waddr     = tc_ff[bsa_pkg::THREAD_W-1:0];
                     res_status_in   = bsa_pkg::RS_REGISTERED;
                     res_assigned_in = tc_ff[bsa_pkg::THREAD_W-1:0];
                     tc_in           = tc_ff + bsa_pkg::TCOUNT_W'(1);
                  end
               end
               bsa_pkg::CMD_REQUEST, bsa_pkg::CMD_RELEASE: begin
                  if (bsa_pkg::TCOUNT_W'(thread_ff) >= tc_ff) begin
                     res_status_in = bsa_pkg::RS_BAD_THREAD;
                     state_in      = bsa_pkg::S_DONE;
                  end else begin
                     state_in = bsa_pkg::S_FETCH;
                  end
               end
               default: begin
                  state_in = bsa_pkg::S_IDLE;
               end
            endcase
         end
         bsa_pkg::S_FETCH: begin
            if (cmd_ff == bsa_pkg::CMD_RELEASE) begin
               state_in = bsa_pkg::S_DONE;
               if (!vu_flags.any_held) begin
                  res_status_in = bsa_pkg::RS_NOTHING_HELD;
               end else begin
                  for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
                     avail_in[r] = (vu_work_sum[r] > bsa_pkg::WORK_W'(bsa_pkg::CNT_MAX)) ?
                                   bsa_pkg::CNT_MAX : vu_work_sum[r][bsa_pkg::CNT_W-1:0];
                  end
                  alloc_we        = 1'b1;
                  res_released_in = alloc_rd;
                  res_status_in   = bsa_pkg::RS_RELEASED;
               end
            end else if (refuse) begin
               res_status_in = refuse_status;
               state_in      = bsa_pkg::S_DONE;
            end else begin
               old_alloc_in = alloc_rd;
               old_avail_in = avail_ff;
               avail_in     = vu_work_diff;
               alloc_we     = 1'b1;
               alloc_wdata  = vu_alloc_sum;
               for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
                  work_in[r] = bsa_pkg::WORK_W'(vu_work_diff[r]);
               end
               done_in   = '0;
               n_in      = '0;
               scan_t_in = '0;
               order_in  = '0;
               state_in  = bsa_pkg::S_SCAN_RD;
            end
         end
         bsa_pkg::S_SCAN_RD: begin
            rd_addr = scan_t_ff[bsa_pkg::THREAD_W-1:0];
            if (scan_t_ff == tc_ff) begin
               alloc_we      = 1'b1;
               alloc_wdata   = old_alloc_ff;
               avail_in      = old_avail_ff;
               res_status_in = bsa_pkg::RS_UNSAFE;
               state_in      = bsa_pkg::S_DONE;
            end else if (done_ff[scan_t_ff[bsa_pkg::THREAD_W-1:0]]) begin
               scan_t_in = scan_t_ff + bsa_pkg::TCOUNT_W'(1);
            end else begin
               state_in = bsa_pkg::S_SCAN_EV;
            end
         end
         bsa_pkg::S_SCAN_EV: begin
            vu_work  = work_ff;
            state_in = bsa_pkg::S_SCAN_RD;
            if (&vu_flags.fits) begin
               done_in[scan_t_ff[bsa_pkg::THREAD_W-1:0]] = 1'b1;
               work_in = vu_work_sum;
               if (n_ff < bsa_pkg::TCOUNT_W'(bsa_pkg::ORDER_ENTRIES)) begin
                  order_nxt[n_ff[bsa_pkg::ORDER_IDX_W-1:0]] =
                     scan_t_ff[bsa_pkg::ORDER_SLOT_W-1:0];
               end
               order_in  = order_nxt;
               n_in      = n_ff + bsa_pkg::TCOUNT_W'(1);
               scan_t_in = '0;
               if (n_ff + bsa_pkg::TCOUNT_W'(1) == tc_ff) begin
                  res_status_in = bsa_pkg::RS_GRANTED;
                  res_order_in  = order_nxt;
                  res_count_in  = bsa_pkg::SCOUNT_W'(n_ff + bsa_pkg::TCOUNT_W'(1));
                  state_in      = bsa_pkg::S_DONE;
               end
            end else begin
               scan_t_in = scan_t_ff + bsa_pkg::TCOUNT_W'(1);
            end
         end
         bsa_pkg::S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               rsp_tvalid_in   = 1'b1;
               rsp_status_in   = res_status_ff;
               rsp_assigned_in = res_assigned_ff;
               rsp_order_in    = res_order_ff;
               rsp_count_in    = res_count_ff;
               rsp_released_in = res_released_ff;
               state_in        = bsa_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bsa_pkg::S_IDLE;
         end
      endcase

      if (csr_we) begin
         for (int r = 0; r < bsa_pkg::NUM_RES; r++) begin
            if (csr_addr == bsa_pkg::CSR_ADDR_W'(r)) begin
               avail_in[r] = csr_wdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= bsa_pkg::S_IDLE;
         tc_ff         <= '0;
         avail_ff      <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tc_ff         <= tc_in;
         avail_ff      <= avail_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      cmd_ff          <= cmd_in;
      thread_ff       <= thread_in;
      amt_ff          <= amt_in;
      old_avail_ff    <= old_avail_in;
      old_alloc_ff    <= old_alloc_in;
      work_ff         <= work_in;
      done_ff         <= done_in;
      n_ff            <= n_in;
      scan_t_ff       <= scan_t_in;
      order_ff        <= order_in;
      res_status_ff   <= res_status_in;
      res_assigned_ff <= res_assigned_in;
      res_order_ff    <= res_order_in;
      res_count_ff    <= res_count_in;
      res_released_ff <= res_released_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_assigned_ff <= rsp_assigned_in;
      rsp_order_ff    <= rsp_order_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_released_ff <= rsp_released_in;
   end

   assign req_tready = (state_ff == bsa_pkg::S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(bsa_pkg::RSP_DATA_W - bsa_pkg::RSP_USED_W)'(0),
                        rsp_released_ff, rsp_count_ff, rsp_order_ff, rsp_assigned_ff};

   a_tc_bound: assert property (@(posedge clock) disable iff (reset)
      tc_ff <= bsa_pkg::TCOUNT_W'(bsa_pkg::NUM_THREADS))
      else $error("thread count beyond table size");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid_ff) |-> $past(state_ff == bsa_pkg::S_DONE))
      else $error("result raised outside done state");

   a_scan_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bsa_pkg::S_SCAN_RD || state_ff == bsa_pkg::S_SCAN_EV) |-> n_ff < tc_ff)
      else $error("finisher count reached thread count inside scan");

   a_scan_candidate: assert property (@(posedge clock) disable iff (reset)
      state_ff == bsa_pkg::S_SCAN_EV |->
         (scan_t_ff < tc_ff) && !done_ff[scan_t_ff[bsa_pkg::THREAD_W-1:0]])
      else $error("evaluating a finished or unregistered thread");

endmodule
